@@ sv/dtq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    localparam int IdW    = 16;
    localparam int DurW   = 32;
    localparam int TimeW  = 48;
    localparam int CmdW   = 2;
    localparam int KindW  = 2;
    localparam int MaxRes = 16;
    localparam int FcntW  = $clog2(MaxRes + 1);

    typedef enum logic [CmdW-1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [KindW-1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_EXPIRE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] deadline;
    } slot_ent_t;

endpackage

`default_nettype wire

@@ sv/dtq_slot_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtq_slot_store #(
    parameter int SLOTS = 16,
    parameter int IdxW  = $clog2(SLOTS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [IdxW-1:0]     rd_addr,
    input  wire logic                wr_en,
    input  wire logic                clr_en,
    input  wire logic [IdxW-1:0]     upd_addr,
    input  wire dtq_pkg::slot_ent_t  wr_ent,
    output logic                     rd_valid_reg,
    output dtq_pkg::slot_ent_t       rd_ent_reg
);
    import dtq_pkg::*;

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    slot_ent_t        mem [SLOTS];

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[upd_addr] = 1'b1;
        end
        if (clr_en)
        begin
            valid_next[upd_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[upd_addr] <= wr_ent;
        end
        rd_ent_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/dtq_select.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtq_select #(
    parameter int SLOTS = 16,
    parameter int IdxW  = $clog2(SLOTS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       cmp_en,
    input  wire dtq_pkg::cmd_t              cmd,
    input  wire logic [dtq_pkg::TimeW-1:0]  now,
    input  wire logic [dtq_pkg::IdW-1:0]    tid,
    input  wire logic [IdxW-1:0]            cmp_idx,
    input  wire logic                       rd_valid,
    input  wire dtq_pkg::slot_ent_t         rd_ent,
    output logic                            found_reg,
    output logic [IdxW-1:0]                 best_idx_reg,
    output dtq_pkg::slot_ent_t              best_ent_reg
);
    import dtq_pkg::*;

    logic take;
    logic earlier;

    // On a tick the earliest due deadline wins, then the lower id, and an
    // exact tie keeps the lower slot. Add and cancel take the first match.
    always_comb
    begin
        earlier = (rd_ent.deadline < best_ent_reg.deadline) ||
                  ((rd_ent.deadline == best_ent_reg.deadline) &&
                   (rd_ent.id < best_ent_reg.id));
        unique case (cmd)
            CMD_TICK:   take = rd_valid && (rd_ent.deadline <= now) &&
                               (!found_reg || earlier);
            CMD_ADD:    take = !rd_valid && !found_reg;
            CMD_CANCEL: take = rd_valid && (rd_ent.id == tid) && !found_reg;
            default:    take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
        end
        else if (cmp_en && take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en && take)
        begin
            best_idx_reg <= cmp_idx;
            best_ent_reg <= rd_ent;
        end
    end

endmodule

`default_nettype wire

@@ sv/deadline_timer_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   cmd, duration, cancel_id
// out      output     out_valid / out_stall kind, res_id, ok, last
//
// Every add, cancel or tick runs a pass over all slots through the slot memory read port and
// the shared compare unit. A tick runs one more pass after each expiry that it finds: a tick
// that expires k timers, below the limit of 16, runs k + 1 passes, and one that reaches the
// limit of 16 expiries runs 16 passes.
// An unused command is taken and gives no item.
// Reset clears time, the id counter and all slot valid bits at once.
// A result held by out_stall blocks the sequencer only when it must emit the next item.

module deadline_timer_queue_top #(
    parameter int SLOTS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [dtq_pkg::CmdW-1:0]   cmd,
    input  wire logic [dtq_pkg::DurW-1:0]   duration,
    input  wire logic [dtq_pkg::IdW-1:0]    cancel_id,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [dtq_pkg::KindW-1:0]       kind,
    output logic [dtq_pkg::IdW-1:0]         res_id,
    output logic                            ok,
    output logic                            last
);
    import dtq_pkg::*;

    localparam int IdxW = $clog2(SLOTS);
    localparam int CntW = $clog2(SLOTS + 1);

    state_t               state_reg;
    state_t               state_next;
    cmd_t                 cmd_reg;
    logic [IdW-1:0]       tid_reg;
    logic [DurW-1:0]      dur_reg;
    logic [TimeW-1:0]     now_reg;
    logic [IdW-1:0]       next_id_reg;
    logic [CntW-1:0]      idx_reg;
    logic                 cmp_vld_reg;
    logic [IdxW-1:0]      cmp_idx_reg;
    logic                 pend_vld_reg;
    logic [IdW-1:0]       pend_id_reg;
    logic [FcntW-1:0]     fcnt_reg;
    logic                 out_valid_reg;
    kind_t                kind_reg;
    logic [IdW-1:0]       id_res_reg;
    logic                 ok_reg;
    logic                 last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 tick_go;
    logic                 last_round;
    logic                 scan_end;
    logic                 start;
    logic                 emit;
    kind_t                e_kind;
    logic [IdW-1:0]       e_id;
    logic                 e_ok;
    logic                 e_last;
    logic                 wr_en;
    logic                 clr_en;
    logic                 pend_load;
    logic                 id_inc;
    slot_ent_t            wr_ent;
    logic                 rd_valid;
    slot_ent_t            rd_ent;
    logic                 found;
    logic [IdxW-1:0]      best_idx;
    slot_ent_t            best_ent;

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        accept      = in_valid && !in_stall;
        out_free    = !out_valid_reg || !out_stall;
        tick_go     = !pend_vld_reg || out_free;
        last_round  = (fcnt_reg == FcntW'(MaxRes - 1));
        scan_end    = (idx_reg == CntW'(SLOTS));
        wr_ent.id       = next_id_reg;
        wr_ent.deadline = now_reg + TimeW'(dur_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_t'(cmd) != CMD_NONE))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                unique case (cmd_reg)
                    CMD_ADD, CMD_CANCEL:
                    begin
                        if (out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (tick_go)
                        begin
                            if (!found)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (last_round)
                            begin
                                state_next = ST_FLUSH;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    CMD_NONE:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        start     = 1'b0;
        emit      = 1'b0;
        e_kind    = KIND_EXPIRE;
        e_id      = pend_id_reg;
        e_ok      = 1'b1;
        e_last    = 1'b1;
        wr_en     = 1'b0;
        clr_en    = 1'b0;
        pend_load = 1'b0;
        id_inc    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                start = accept && (cmd_t'(cmd) != CMD_NONE);
            end
            ST_SCAN:
            begin
                start = 1'b0;
            end
            ST_FINISH:
            begin
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        emit   = out_free;
                        e_kind = KIND_ADD;
                        e_id   = found ? next_id_reg : '0;
                        e_ok   = found;
                        wr_en  = out_free && found;
                        id_inc = out_free && found;
                    end
                    CMD_CANCEL:
                    begin
                        emit   = out_free;
                        e_kind = KIND_CANCEL;
                        e_id   = tid_reg;
                        e_ok   = found;
                        clr_en = out_free && found;
                    end
                    CMD_TICK:
                    begin
                        // The previous expiry is held back until it is known
                        // whether another one follows it.
                        emit   = tick_go && pend_vld_reg;
                        e_last = !found;
                        if (tick_go && found)
                        begin
                            clr_en    = 1'b1;
                            pend_load = 1'b1;
                            start     = !last_round;
                        end
                    end
                    CMD_NONE:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            ST_FLUSH:
            begin
                emit = out_free;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            next_id_reg   <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN) && !scan_end;
            if (accept && (cmd_t'(cmd) == CMD_TICK))
            begin
                now_reg <= now_reg + TimeW'(1);
            end
            if (id_inc)
            begin
                next_id_reg <= next_id_reg + IdW'(1);
            end
            if (start)
            begin
                idx_reg <= '0;
            end
            else if ((state_reg == ST_SCAN) && !scan_end)
            begin
                idx_reg <= idx_reg + CntW'(1);
            end
            if (accept)
            begin
                pend_vld_reg <= 1'b0;
                fcnt_reg     <= '0;
            end
            else if (pend_load)
            begin
                pend_vld_reg <= 1'b1;
                fcnt_reg     <= fcnt_reg + FcntW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            tid_reg <= cancel_id;
            dur_reg <= duration;
        end
        cmp_idx_reg <= idx_reg[IdxW-1:0];
        if (pend_load)
        begin
            pend_id_reg <= best_ent.id;
        end
        if (emit)
        begin
            kind_reg   <= e_kind;
            id_res_reg <= e_id;
            ok_reg     <= e_ok;
            last_reg   <= e_last;
        end
    end

    dtq_slot_store #(
        .SLOTS (SLOTS),
        .IdxW  (IdxW)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_addr      (idx_reg[IdxW-1:0]),
        .wr_en        (wr_en),
        .clr_en       (clr_en),
        .upd_addr     (best_idx),
        .wr_ent       (wr_ent),
        .rd_valid_reg (rd_valid),
        .rd_ent_reg   (rd_ent)
    );

    dtq_select #(
        .SLOTS (SLOTS),
        .IdxW  (IdxW)
    ) u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmp_en       (cmp_vld_reg),
        .cmd          (cmd_reg),
        .now          (now_reg),
        .tid          (tid_reg),
        .cmp_idx      (cmp_idx_reg),
        .rd_valid     (rd_valid),
        .rd_ent       (rd_ent),
        .found_reg    (found),
        .best_idx_reg (best_idx),
        .best_ent_reg (best_ent)
    );

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign res_id       = id_res_reg;
    assign ok           = ok_reg;
    assign last         = last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || !out_stall))
        else $error("result loaded while a held result was not taken");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg && (state_reg != ST_IDLE) |-> (cmd_reg == CMD_TICK))
        else $error("pending expiry outside a tick");

    a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_vld_reg && (fcnt_reg == FcntW'(MaxRes)))
        else $error("flush without a full set of expiries");

    a_scan_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !cmp_vld_reg)
        else $error("compare still running at the end of a pass");

endmodule

`default_nettype wire

@@ dv/deadline_timer_queue_checker.sv @@
`timescale 1ns / 1ps

module deadline_timer_queue_checker #(
    parameter int SLOTS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic [dtq_pkg::CmdW-1:0]   cmd,
    input  wire logic [dtq_pkg::DurW-1:0]   duration,
    input  wire logic [dtq_pkg::IdW-1:0]    cancel_id,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [dtq_pkg::KindW-1:0]  kind,
    input  wire logic [dtq_pkg::IdW-1:0]    res_id,
    input  wire logic                       ok,
    input  wire logic                       last,
    output int                              fail_count,
    output int                              rsp_backlog
);
    import dtq_pkg::*;

    typedef struct packed {
        kind_t          kind;
        logic [IdW-1:0] id;
        logic           ok;
        logic           last;
    } timer_rsp_t;

    logic [TimeW-1:0] time_now;
    logic [IdW-1:0]   id_next;
    logic             slot_busy [SLOTS];
    logic [IdW-1:0]   slot_tid [SLOTS];
    logic [TimeW-1:0] slot_due [SLOTS];
    timer_rsp_t       timer_rsps [$];

    initial fail_count = 0;

    function automatic timer_rsp_t make_rsp(kind_t k, logic [IdW-1:0] id, logic good);
        timer_rsp_t r;
        r.kind = k;
        r.id   = id;
        r.ok   = good;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic run_timer_cmd(input logic [CmdW-1:0] c, input logic [DurW-1:0] d,
                                 input logic [IdW-1:0] t);
        int         best;
        int         fired;
        int         slot;
        int         size_in;
        logic       found;
        timer_rsp_t tail;
        size_in = timer_rsps.size();
        case (c)
            CMD_TICK:
            begin
                time_now = time_now + TimeW'(1);
                fired = 0;
                best = 0;
                while (fired < MaxRes && best >= 0)
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_busy[i] && slot_due[i] <= time_now)
                        begin
                            if (best < 0 || slot_due[i] < slot_due[best] ||
                                (slot_due[i] == slot_due[best] &&
                                 slot_tid[i] < slot_tid[best]))
                                best = i;
                        end
                    end
                    if (best >= 0)
                    begin
                        slot_busy[best] = 1'b0;
                        timer_rsps.push_back(make_rsp(KIND_EXPIRE, slot_tid[best], 1'b1));
                        fired++;
                    end
                end
            end
            CMD_ADD:
            begin
                slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!slot_busy[i])
                        slot = i;
                end
                if (slot < 0)
                    timer_rsps.push_back(make_rsp(KIND_ADD, '0, 1'b0));
                else
                begin
                    slot_busy[slot] = 1'b1;
                    slot_tid[slot] = id_next;
                    slot_due[slot] = time_now + TimeW'(d);
                    timer_rsps.push_back(make_rsp(KIND_ADD, id_next, 1'b1));
                    id_next = id_next + IdW'(1);
                end
            end
            CMD_CANCEL:
            begin
                found = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && slot_busy[i] && slot_tid[i] == t)
                    begin
                        slot_busy[i] = 1'b0;
                        found = 1'b1;
                    end
                end
                timer_rsps.push_back(make_rsp(KIND_CANCEL, t, found));
            end
            default:
            begin
            end
        endcase
        if (timer_rsps.size() > size_in)
        begin
            tail = timer_rsps.pop_back();
            tail.last = 1'b1;
            timer_rsps.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now = '0;
            id_next = '0;
            for (int i = 0; i < SLOTS; i++)
                slot_busy[i] = 1'b0;
            timer_rsps.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (timer_rsps.size() == 0)
                begin
                    $error("result kind %0d id %0h arrived with none pending", kind,
                           res_id);
                    fail_count++;
                end
                else
                begin
                    timer_rsp_t want;
                    want = timer_rsps.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (res_id !== want.id)
                    begin
                        $error("res_id: expected %0h, actual %0h", want.id, res_id);
                        fail_count++;
                    end
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", want.ok, ok);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                run_timer_cmd(cmd, duration, cancel_id);
        end
        rsp_backlog <= timer_rsps.size();
    end

endmodule

@@ dv/tb_deadline_timer_queue_top.sv @@
`timescale 1ns / 1ps

module tb_deadline_timer_queue_top;

    import dtq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TickCycles  = (MaxRes + 1) * (SLOTS + 2) + 1;
    localparam int IdleLimit   = 6 * TickCycles;
    localparam int DrainCycles = TickCycles + 10;
    localparam int RandomItems = 180;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CmdW-1:0]   cmd = CMD_TICK;
    logic [DurW-1:0]   duration = '0;
    logic [IdW-1:0]    cancel_id = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    res_id;
    logic              ok;
    logic              last;

    int   fail_count;
    int   rsp_backlog;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   stall_next;
    int   idle_cycles = 0;
    int   add_count = 0;

    always #5 clk = ~clk;

    deadline_timer_queue_top #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .duration(duration),
        .cancel_id(cancel_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .res_id(res_id),
        .ok(ok),
        .last(last)
    );

    deadline_timer_queue_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .duration(duration),
        .cancel_id(cancel_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .res_id(res_id),
        .ok(ok),
        .last(last),
        .fail_count(fail_count),
        .rsp_backlog(rsp_backlog)
    );

    // After each item it takes, the receiver may raise out_stall for a random span, except while quiet is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_next = 0;
        else if (out_valid && !out_stall)
            stall_next = quiet ? 0 : $urandom_range(0, 3);
        else
            stall_next = (stall_left > 0) ? stall_left - 1 : 0;
        stall_left <= stall_next;
        out_stall <= (stall_next != 0);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("[deadline_timer_queue_top] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input cmd_t c, input logic [DurW-1:0] d, input logic [IdW-1:0] t);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        duration <= d;
        cancel_id <= t;
        if (c == CMD_ADD)
            add_count++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_timers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rsp_backlog != 0)
            @(posedge clk);
    endtask

    task automatic add_burst(input int adds, input int dmax, input int ticks);
        for (int i = 0; i < adds; i++)
            send_item(CMD_ADD, DurW'($urandom_range(0, dmax)), IdW'($urandom));
        for (int i = 0; i < ticks; i++)
            send_item(CMD_TICK, $urandom, IdW'($urandom));
    endtask

    function automatic logic [DurW-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 70)
            return $urandom_range(1, 12);
        if (r < 95)
            return $urandom_range(13, 200);
        return $urandom;
    endfunction

    function automatic logic [IdW-1:0] pick_cancel_id();
        int lo;
        if ($urandom_range(0, 4) == 0)
            return IdW'($urandom_range(0, 65535));
        lo = (add_count > 24) ? add_count - 24 : 0;
        return IdW'($urandom_range(lo, add_count));
    endfunction

    initial
    begin
        int items;
        int r;
        int adds;
        int ticks;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_item(CMD_CANCEL, 32'd0, 16'd0);
        send_item(CMD_NONE, $urandom, IdW'($urandom));
        send_item(CMD_TICK, 32'd0, 16'd0);
        send_item(CMD_ADD, 32'd0, 16'd0);
        send_item(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(CMD_ADD, 32'd2, 16'd0);
        send_item(CMD_ADD, 32'd2, 16'd0);
        send_item(CMD_ADD, 32'd1, 16'd0);
        send_item(CMD_CANCEL, 32'd0, 16'd1);
        send_item(CMD_CANCEL, 32'd0, 16'hFFFF);
        send_item(CMD_TICK, 32'd0, 16'd0);
        send_item(CMD_TICK, 32'd0, 16'd0);
        drain_timers();

        // Fill the table past its size, then expire every timer on a single tick.
        add_burst(SLOTS + 1, 0, 1);

        items = 0;
        while (items < RandomItems)
        begin
            if ($urandom_range(0, 39) == 0)
                quiet <= ~quiet;
            if ($urandom_range(0, 32) == 0)
                drain_timers();
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                adds = $urandom_range(6, SLOTS + 1);
                ticks = $urandom_range(1, 4);
                add_burst(adds, 3, ticks);
                items += adds + ticks;
            end
            else if (r < 12)
                send_item(CMD_NONE, $urandom, IdW'($urandom));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_item(CMD_ADD, pick_duration(), IdW'($urandom));
                else if (r < 75)
                    send_item(CMD_TICK, $urandom, IdW'($urandom));
                else
                    send_item(CMD_CANCEL, $urandom, pick_cancel_id());
                items++;
            end
        end

        drain_timers();
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && rsp_backlog == 0)
            $display("[deadline_timer_queue_top] OK");
        else
            $display("[deadline_timer_queue_top] ERROR");
        $finish;
    end

endmodule
